// ===== sv/iol_pkg.sv =====
package iol_pkg;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    localparam logic [ACTION_W-1:0] ACT_READ     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_HEAD = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_APPEND   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_INS_AT   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELETE   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } cmd_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [LEN_W-1:0]         list_length;
    } res_beat_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic del;
        logic rd;
    } cell_cmd_t;

endpackage

// ===== sv/iol_cell.sv =====
module iol_cell #(
    parameter int INDEX       = 0,
    parameter int IDX_W       = 6,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  iol_pkg::cell_cmd_t     cmd,
    input  logic [IDX_W-1:0]       target,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic [VALUE_WIDTH-1:0] below_value,
    input  logic [VALUE_WIDTH-1:0] above_value,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [VALUE_WIDTH-1:0] read_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   at_me;
    logic                   past_target;

    assign at_me       = (target == MY_IDX);
    assign past_target = (MY_IDX > target);

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (at_me)
                value_next = new_value;
            else if (past_target)
                value_next = below_value;
        end
        else if (cmd.del && (at_me || past_target))
        begin
            value_next = above_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    // only the addressed cell puts its entry on the or-bus
    assign read_data = (cmd.rd && at_me) ? value_reg : '0;

endmodule

// ===== sv/indexed_ordered_list_unit.sv =====
// a command beat's result is registered and offered in the cycle after acceptance
// throughput: one command per cycle while cmd_stall is low; every cell of the shift chain moves in the same cycle
// a result held by res_stall stalls the command side until it is taken
// reset: entry count and result valid are cleared; cell contents stay undefined
// until written, and only entries below the count are ever read
module indexed_ordered_list_unit #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  iol_pkg::cmd_beat_t cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output iol_pkg::res_beat_t res
);
    import iol_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    res_beat_t              res_reg;
    res_beat_t              res_next;

    logic                   accept;
    logic [CMP_W-1:0]       cmp_count;
    logic [CMP_W-1:0]       cmp_pos;
    logic [CMP_W-1:0]       target_cmp;
    logic [CMP_W-1:0]       ins_at;
    logic                   is_ins;
    logic                   rd_oor;
    logic [STATUS_W-1:0]    status;
    cell_cmd_t              cell_cmd;
    logic [IDX_W-1:0]       target;
    logic [63:0]            item_ext;
    logic [VALUE_WIDTH-1:0] new_value;
    logic [VALUE_WIDTH-1:0] rd_any;
    logic [VALUE_WIDTH-1:0] rd_word;
    logic [63:0]            rd_wide;

    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_rd    [CAPACITY];

    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign cmp_count = CMP_W'(count_reg);
    assign cmp_pos   = CMP_W'(cmd.position);

    assign item_ext  = {{32{cmd.item_value[DATA_W-1]}}, cmd.item_value};
    assign new_value = item_ext[VALUE_WIDTH-1:0];

    always_comb
    begin
        cell_cmd   = '0;
        target_cmp = '0;
        ins_at     = '0;
        is_ins     = 1'b0;
        rd_oor     = 1'b0;
        status     = ST_DONE;
        count_next = count_reg;
        case (cmd.action)
            ACT_READ:
            begin
                if (cmp_pos < cmp_count)
                begin
                    cell_cmd.rd = accept;
                    target_cmp  = cmp_pos;
                end
                else
                begin
                    rd_oor = 1'b1;
                    status = ST_RANGE;
                end
            end
            ACT_INS_HEAD:
            begin
                is_ins = 1'b1;
                ins_at = '0;
            end
            ACT_APPEND:
            begin
                is_ins = 1'b1;
                ins_at = cmp_count;
            end
            ACT_INS_AT:
            begin
                is_ins = 1'b1;
                ins_at = cmp_pos;
            end
            ACT_DELETE:
            begin
                if (cmp_pos < cmp_count)
                begin
                    cell_cmd.del = accept;
                    target_cmp   = cmp_pos;
                    if (accept)
                        count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status = ST_RANGE;
                end
            end
            default:
            begin
                status = ST_DONE;
            end
        endcase

        // the range check wins over the full check
        if (is_ins)
        begin
            if (ins_at > cmp_count)
                status = ST_RANGE;
            else if (cmp_count == CAP_C)
                status = ST_FULL;
            else
            begin
                cell_cmd.ins = accept;
                target_cmp   = ins_at;
                if (accept)
                    count_next = count_reg + CNT_W'(1);
            end
        end
    end

    assign target = target_cmp[IDX_W-1:0];

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] below;
            logic [VALUE_WIDTH-1:0] above;
            if (k == 0)
            begin : g_first
                assign below = new_value;
            end
            else
            begin : g_mid_lo
                assign below = cell_value[k-1];
            end
            if (k == CAPACITY - 1)
            begin : g_last
                assign above = cell_value[k];
            end
            else
            begin : g_mid_hi
                assign above = cell_value[k+1];
            end

            iol_cell #(
                .INDEX       (k),
                .IDX_W       (IDX_W),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk         (clk),
                .cmd         (cell_cmd),
                .target      (target),
                .new_value   (new_value),
                .below_value (below),
                .above_value (above),
                .value       (cell_value[k]),
                .read_data   (cell_rd[k])
            );
        end
    endgenerate

    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_any = rd_any | cell_rd[i];
    end

    // out-of-range read gives all ones at the stored width
    assign rd_word = rd_oor ? {VALUE_WIDTH{1'b1}} : rd_any;
    assign rd_wide = 64'(rd_word);

    always_comb
    begin
        res_next.read_value  = rd_wide[DATA_W-1:0];
        res_next.status      = status;
        res_next.list_length = LEN_W'(count_next);
        res_valid_next       = accept || (res_valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CAP_C)
        else $error("entry count above capacity");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("accepted command gave no result");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status == ST_FULL) |-> (CMP_W'(count_reg) == CAP_C))
        else $error("full status with room left");

    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cell_cmd.del) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("delete did not shrink the list");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cell_cmd.ins) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

endmodule
